/* hw/rtl/murmur_hash_64a_engine_top_assert.svh */
`ifndef MURMUR_HASH_64A_ENGINE_TOP_ASSERT_SVH
`define MURMUR_HASH_64A_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk outside reset
`define MHE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on clk outside reset
`define MHE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

/* hw/rtl/mhe_pkg.sv */
package mhe_pkg;

  // Mixing constants
  localparam logic [63:0] MIX_M = 64'hc6a4a7935bd1e995;
  localparam int          MIX_R = 47;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TAIL = 2'd1,
    KIND_FULL = 2'd2
  } mix_kind_t;

  typedef struct packed {
    mix_kind_t   kind;
    logic        first;
    logic        last;
    logic        len_err;
    logic [63:0] data;
    logic [63:0] seed;
    logic [31:0] msg_len;
  } cmd_t;

  function automatic logic [63:0] xorshift(input logic [63:0] h);
    return h ^ (h >> MIX_R);
  endfunction

endpackage

/* hw/rtl/murmur_hash_64a_engine_top.sv */
// Flow: the back end takes each item from the command queue in ST_IDLE, then runs its
//   64-bit multiplies (zero to five per item) one after another, each as three partial products.
// The back end starts a new item only once it is done with the last; one shared 32x32
//   multiplier, three partial products per multiply, sets this.
// Reset: synchronous, active-low rst_n clears the seed, message state, queue, back-end state and result valid.
module murmur_hash_64a_engine_top
  import mhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        push,
  output logic        full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  input  logic [31:0] in_msg_len,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_hash_value,
  output logic        out_length_error
);

  logic q_push;
  cmd_t q_wr_cmd;
  logic q_full;
  logic q_pop;
  logic q_valid;
  cmd_t q_rd_cmd;

  assign full = q_full;

  mhe_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .push           (push),
    .q_full         (q_full),
    .in_data_word   (in_data_word),
    .in_valid_bytes (in_valid_bytes),
    .in_last        (in_last),
    .in_msg_len     (in_msg_len),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd)
  );

  mhe_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (q_push),
    .wr_cmd   (q_wr_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_rd_cmd)
  );

  mhe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_cmd            (q_rd_cmd),
    .q_pop            (q_pop),
    .empty            (empty),
    .pop              (pop),
    .out_hash_value   (out_hash_value),
    .out_length_error (out_length_error)
  );

endmodule

/* hw/rtl/mhe_front.sv */
module mhe_front
  import mhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  input  logic        push,
  input  logic        q_full,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_valid_bytes,
  input  logic        in_last,
  input  logic [31:0] in_msg_len,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [63:0] seed_r;
  logic        in_msg_r, in_msg_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic        err_r, err_nxt;
  logic [31:0] len_r, len_nxt;

  logic        first;
  logic [31:0] cnt_base;
  logic [31:0] len_cur;
  logic [3:0]  nb;
  logic [32:0] sum;
  logic [63:0] masked;

  assign q_push = push && !q_full;
  assign first  = !in_msg_r;

  // Classify the word and track the byte count
  always_comb begin
    cnt_base = first ? 32'd0 : cnt_r;
    len_cur  = first ? in_msg_len : len_r;
    err_nxt  = first ? 1'b0 : err_r;
    nb       = in_valid_bytes;
    if (in_valid_bytes > 4'd8) begin
      nb      = 4'd8;
      err_nxt = 1'b1;
    end
    if (nb < 4'd8 && !in_last) begin
      err_nxt = 1'b1;
    end
    sum = {1'b0, cnt_base} + {29'b0, nb};
    if (sum[32]) begin
      cnt_nxt = 32'hFFFF_FFFF;
      err_nxt = 1'b1;
    end else begin
      cnt_nxt = sum[31:0];
    end
    len_nxt    = len_cur;
    in_msg_nxt = !in_last;
  end

  // Drop bytes above the valid count
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < nb) ? in_data_word[8*i +: 8] : 8'd0;
    end
  end

  // Build the queue entry
  always_comb begin
    q_cmd.kind    = (nb == 4'd8) ? KIND_FULL : ((nb != 4'd0) ? KIND_TAIL : KIND_NONE);
    q_cmd.first   = first;
    q_cmd.last    = in_last;
    q_cmd.len_err = err_nxt || (cnt_nxt != len_cur);
    q_cmd.data    = masked;
    q_cmd.seed    = seed_r;
    q_cmd.msg_len = in_msg_len;
  end

  // Hold seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
    end else if (cfg_wr_en) begin
      seed_r <= cfg_wr_data;
    end
  end

  // Advance message state on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_msg_r <= 1'b0;
      cnt_r    <= 32'd0;
      err_r    <= 1'b0;
      len_r    <= 32'd0;
    end else if (q_push) begin
      in_msg_r <= in_msg_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      len_r    <= len_nxt;
    end
  end

endmodule

/* hw/rtl/mhe_fifo.sv */
module mhe_fifo
  import mhe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output cmd_t rd_cmd
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt;
  logic [QPTR_W-1:0] rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = ent_r[rp_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // Advance pointers and occupancy
  always_comb begin
    wp_nxt  = do_wr ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_rd ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      ent_r[wp_r] <= wr_cmd;
    end
  end

endmodule

/* hw/rtl/mhe_back.sv */
module mhe_back
  import mhe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_hash_value,
  output logic        out_length_error
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_INIT = 6'b000010,
    ST_KEY1 = 6'b000100,
    ST_KEY2 = 6'b001000,
    ST_HASH = 6'b010000,
    ST_FIN  = 6'b100000
  } bstate_t;

  typedef struct packed {
    bstate_t     st;
    logic [63:0] x;
  } disp_t;

  // Partial-product phases of one 64x64 low-half multiply
  localparam logic [1:0] PH_LO = 2'd0;
  localparam logic [1:0] PH_HL = 2'd1;
  localparam logic [1:0] PH_LH = 2'd2;

  bstate_t     st_r, st_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] h_r, h_nxt;
  cmd_t        cmd_r, cmd_nxt;
  logic        out_vld_r, out_vld_nxt;
  logic [63:0] out_hash_r, out_hash_nxt;
  logic        out_err_r, out_err_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic        mul_last;
  logic        out_free;
  logic        stall;
  logic [63:0] h_init;
  disp_t       d_idle, d_init;

  // Pick the next step from the word kind
  function automatic disp_t dispatch(input cmd_t c, input logic [63:0] h);
    disp_t d;
    d.st = ST_IDLE;
    d.x  = h;
    case (c.kind)
      KIND_FULL: begin
        d.st = ST_KEY1;
        d.x  = c.data;
      end
      KIND_TAIL: begin
        d.st = ST_HASH;
        d.x  = h ^ c.data;
      end
      default: begin
        if (c.last) begin
          d.st = ST_FIN;
          d.x  = xorshift(h);
        end
      end
    endcase
    return d;
  endfunction

  // One 32x32 partial product per cycle into the accumulator, unless ST_FIN stalls on an unread result
  assign mul_a    = (ph_r == PH_HL) ? x_r[63:32] : x_r[31:0];
  assign mul_b    = (ph_r == PH_LH) ? MIX_M[63:32] : MIX_M[31:0];
  assign prod     = mul_a * mul_b;
  assign acc_nxt  = (ph_r == PH_LO) ? prod : {acc_r[63:32] + prod[31:0], acc_r[31:0]};
  assign mul_last = (ph_r == PH_LH);

  assign out_free = !out_vld_r || pop;
  assign stall    = (st_r == ST_FIN) && mul_last && !out_free;
  assign h_init   = cmd_r.seed ^ acc_nxt;
  assign d_idle   = dispatch(q_cmd, h_r);
  assign d_init   = dispatch(cmd_r, h_init);

  assign empty            = !out_vld_r;
  assign out_hash_value   = out_hash_r;
  assign out_length_error = out_err_r;

  // Sequence the mixing steps
  always_comb begin
    st_nxt       = st_r;
    ph_nxt       = ph_r;
    x_nxt        = x_r;
    h_nxt        = h_r;
    cmd_nxt      = cmd_r;
    q_pop        = 1'b0;
    out_vld_nxt  = out_vld_r && !pop;
    out_hash_nxt = out_hash_r;
    out_err_nxt  = out_err_r;
    case (st_r)
      ST_IDLE: begin
        ph_nxt = PH_LO;
        if (q_valid) begin
          q_pop   = 1'b1;
          cmd_nxt = q_cmd;
          if (q_cmd.first) begin
            st_nxt = ST_INIT;
            x_nxt  = {32'd0, q_cmd.msg_len};
          end else begin
            st_nxt = d_idle.st;
            x_nxt  = d_idle.x;
          end
        end
      end
      default: begin
        if (!stall) begin
          ph_nxt = mul_last ? PH_LO : ph_r + 2'd1;
        end
        if (mul_last && !stall) begin
          case (st_r)
            ST_INIT: begin
              h_nxt  = h_init;
              st_nxt = d_init.st;
              x_nxt  = d_init.x;
            end
            ST_KEY1: begin
              st_nxt = ST_KEY2;
              x_nxt  = xorshift(acc_nxt);
            end
            ST_KEY2: begin
              st_nxt = ST_HASH;
              x_nxt  = h_r ^ acc_nxt;
            end
            ST_HASH: begin
              h_nxt = acc_nxt;
              if (cmd_r.last) begin
                st_nxt = ST_FIN;
                x_nxt  = xorshift(acc_nxt);
              end else begin
                st_nxt = ST_IDLE;
              end
            end
            ST_FIN: begin
              out_vld_nxt  = 1'b1;
              out_hash_nxt = xorshift(acc_nxt);
              out_err_nxt  = cmd_r.len_err;
              st_nxt       = ST_IDLE;
            end
            default: begin
              st_nxt = ST_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      ph_r      <= PH_LO;
      out_vld_r <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      ph_r      <= ph_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Hold datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    h_r        <= h_nxt;
    cmd_r      <= cmd_nxt;
    out_hash_r <= out_hash_nxt;
    out_err_r  <= out_err_nxt;
    if (!stall) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

/* hw/rtl/mhe_checker.sv */
`include "murmur_hash_64a_engine_top_assert.svh"

module mhe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        push,
  input logic        full,
  input logic        in_last,
  input logic        empty,
  input logic        pop,
  input logic [63:0] out_hash_value,
  input logic        out_length_error
);

  logic [3:0] pend_r, pend_nxt;
  logic       last_in, res_out;

  assign last_in = push && !full && in_last;
  assign res_out = pop && !empty;

  // Count messages closed but not yet taken
  always_comb begin
    pend_nxt = pend_r;
    if (last_in && !res_out) begin
      pend_nxt = pend_r + 4'd1;
    end else if (!last_in && res_out) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 4'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `MHE_ASSERT_NOW(a_reset_clear, $rose(rst_n), empty && !full)
  `MHE_ASSERT_NOW(a_no_invented, !empty, pend_r != 4'd0)
  `MHE_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_hash_value) && $stable(out_length_error))

endmodule

bind murmur_hash_64a_engine_top mhe_checker u_chk (.*);

/* dv/murmur_hash_64a_engine_top_test.sv */
`timescale 1ns / 1ps

module murmur_hash_64a_engine_top_test;
  import mhe_pkg::*;

  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 3000;
  localparam int PHASE_WORDS  = 140;

  typedef struct packed {
    logic [63:0] hash;
    logic        len_err;
  } digest_t;

  // Track the open message and hold the digests still owed by the block
  class msg_hash_tracker;
    logic [63:0] seed;
    logic [63:0] run_hash;
    logic        open;
    logic [31:0] byte_cnt;
    logic        err_seen;
    logic [31:0] len_lat;
    digest_t     digest_q[$];
    int          mismatches;

    function new();
      seed       = '0;
      run_hash   = '0;
      open       = 1'b0;
      byte_cnt   = '0;
      err_seen   = 1'b0;
      len_lat    = '0;
      mismatches = 0;
    endfunction

    function void set_seed(logic [63:0] value);
      seed = value;
    endfunction

    function int pending();
      return digest_q.size();
    endfunction

    // Mix one accepted word into the running hash; queue a digest on the last word
    function void take_word(logic [63:0] word, logic [3:0] vb, logic lst,
                            logic [31:0] mlen);
      logic [63:0] h;
      logic [63:0] k;
      logic [63:0] mask;
      logic [32:0] sum;
      int unsigned nb;
      digest_t     d;
      if (!open) begin
        run_hash = seed ^ (64'(mlen) * MIX_M);
        byte_cnt = '0;
        err_seen = 1'b0;
        len_lat  = mlen;
        open     = 1'b1;
      end
      nb = vb;
      // oversized byte count acts as a full word
      if (nb > 8) begin
        nb = 8;
        err_seen = 1'b1;
      end
      if (nb < 8 && !lst) err_seen = 1'b1;
      // saturate the byte count
      sum = {1'b0, byte_cnt} + 33'(nb);
      if (sum[32]) begin
        byte_cnt = '1;
        err_seen = 1'b1;
      end else begin
        byte_cnt = sum[31:0];
      end
      h = run_hash;
      if (nb == 8) begin
        k = word * MIX_M;
        k = k ^ (k >> MIX_R);
        k = k * MIX_M;
        h = h ^ k;
        h = h * MIX_M;
      end else if (nb > 0) begin
        mask = (64'd1 << (8 * nb)) - 64'd1;
        h = h ^ (word & mask);
        h = h * MIX_M;
      end
      run_hash = h;
      if (!lst) return;
      // finalize and close the message
      h = h ^ (h >> MIX_R);
      h = h * MIX_M;
      h = h ^ (h >> MIX_R);
      d.hash    = h;
      d.len_err = err_seen || (byte_cnt != len_lat);
      digest_q.push_back(d);
      open     = 1'b0;
      run_hash = '0;
      byte_cnt = '0;
      err_seen = 1'b0;
    endfunction

    // Compare one popped result with the oldest owed digest
    function void check_digest(logic [63:0] hv, logic le);
      digest_t d;
      if (digest_q.size() == 0) begin
        $error("hash_value: no result expected, got %h (length_error %b)", hv, le);
        mismatches++;
        return;
      end
      d = digest_q.pop_front();
      if (hv !== d.hash) begin
        $error("hash_value: expected %h, actual %h", d.hash, hv);
        mismatches++;
      end
      if (le !== d.len_err) begin
        $error("length_error: expected %b, actual %b", d.len_err, le);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_valid_bytes = '0;
  logic        in_last = 1'b0;
  logic [31:0] in_msg_len = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_hash_value;
  logic        out_length_error;

  msg_hash_tracker tracker;
  logic            calm = 1'b0;
  int              words_sent = 0;
  int              idle_cycles = 0;
  int              pop_hold = 0;
  logic [63:0]     seed_plan[6];

  murmur_hash_64a_engine_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push             (push),
    .full             (full),
    .in_data_word     (in_data_word),
    .in_valid_bytes   (in_valid_bytes),
    .in_last          (in_last),
    .in_msg_len       (in_msg_len),
    .empty            (empty),
    .pop              (pop),
    .out_hash_value   (out_hash_value),
    .out_length_error (out_length_error)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stall the result side in random bursts, never once the run turns calm
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (calm) begin
      pop <= 1'b1;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      pop <= 1'b0;
      pop_hold = $urandom_range(1, 11) - 1;
    end else begin
      pop <= 1'b1;
    end
  end

  // Observe both handshakes and guard against a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (push && !full) begin
        tracker.take_word(in_data_word, in_valid_bytes, in_last, in_msg_len);
      end
      if (pop && !empty) begin
        tracker.check_digest(out_hash_value, out_length_error);
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Offer one item, with an optional gap ahead of it, and hold until accepted
  task automatic send_word(logic [63:0] w, logic [3:0] vb, logic lst, logic [31:0] ml);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push           <= 1'b1;
    in_data_word   <= w;
    in_valid_bytes <= vb;
    in_last        <= lst;
    in_msg_len     <= ml;
    do @(posedge clk); while (full);
    words_sent++;
  endtask

  // Write the seed once the block has drained
  task automatic write_seed(logic [63:0] value);
    push <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tracker.set_seed(value);
  endtask

  // Send one message: mostly well formed, sometimes with bad counts or lengths
  task automatic send_message(bit clean);
    int          nfull;
    int          tail;
    logic [31:0] mlen;
    logic [3:0]  vb;
    nfull = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 4);
    tail  = $urandom_range(0, 7);
    if (clean) begin
      mlen = 32'(nfull * 8 + tail);
      if (tail == 0 && nfull > 0 && $urandom_range(0, 1) == 1) begin
        for (int i = 0; i < nfull; i++)
          send_word(rand_word(), 4'd8, i == nfull - 1, i == 0 ? mlen : $urandom);
      end else begin
        for (int i = 0; i < nfull; i++)
          send_word(rand_word(), 4'd8, 1'b0, i == 0 ? mlen : $urandom);
        send_word(rand_word(), 4'(tail), 1'b1, nfull == 0 ? mlen : $urandom);
      end
    end else begin
      mlen = ($urandom_range(0, 1) == 1) ? $urandom : 32'(nfull * 8 + tail);
      for (int i = 0; i <= nfull; i++) begin
        vb = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'd8;
        send_word(rand_word(), vb, i == nfull, mlen);
      end
    end
  endtask

  initial begin
    tracker = new();
    seed_plan[0] = '1;
    seed_plan[1] = rand_word();
    seed_plan[2] = 64'd1;
    seed_plan[3] = 64'h8000_0000_0000_0000;
    seed_plan[4] = rand_word();
    seed_plan[5] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, extreme data, several tail sizes, malformed words
    send_word('0, 4'd0, 1'b1, 32'd0);
    send_word('1, 4'd8, 1'b1, 32'd8);
    send_word('0, 4'd8, 1'b1, 32'd8);
    send_word('1, 4'd1, 1'b1, 32'd1);
    send_word('1, 4'd7, 1'b1, 32'd7);
    send_word(rand_word(), 4'd3, 1'b1, 32'd3);
    send_word('1, 4'd15, 1'b1, 32'd8);
    send_word(rand_word(), 4'd9, 1'b0, 32'd16);
    send_word(rand_word(), 4'd8, 1'b1, 32'd0);
    send_word(rand_word(), 4'd5, 1'b0, 32'd13);
    send_word(rand_word(), 4'd8, 1'b1, 32'd0);
    send_word(rand_word(), 4'd0, 1'b0, 32'd8);
    send_word(rand_word(), 4'd8, 1'b1, 32'd0);
    send_word(rand_word(), 4'd8, 1'b0, 32'hFFFF_FFFF);
    send_word(rand_word(), 4'd8, 1'b1, 32'd0);
    send_word(rand_word(), 4'd8, 1'b0, 32'd5);
    send_word(rand_word(), 4'd8, 1'b0, 32'd0);
    send_word(rand_word(), 4'd2, 1'b1, 32'd0);
    send_word(rand_word(), 4'd8, 1'b0, 32'd8);
    send_word('0, 4'd0, 1'b1, 32'd0);

    // Random phases, one seed each; the last phase runs without stalls
    for (int p = 0; p < 6; p++) begin
      int target;
      write_seed(seed_plan[p]);
      if (p == 5) calm <= 1'b1;
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_message($urandom_range(0, 5) != 0);
    end

    // Drain and report
    push <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    tracker.mismatches += tracker.pending();
    if (tracker.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/mhe_pkg.sv
hw/rtl/mhe_front.sv
hw/rtl/mhe_fifo.sv
hw/rtl/mhe_back.sv
hw/rtl/murmur_hash_64a_engine_top.sv
hw/rtl/mhe_checker.sv
dv/murmur_hash_64a_engine_top_test.sv
